FILE: src/avtp_rx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AVTP audio stream receive tracker - shared types and constants
// Word layouts for both channels, command codes and internal stage snapshot.
// ----------------------------------------------------------------------------
package avtp_rx_pkg;

    localparam int SEQ_W    = 32;
    localparam int TS_W     = 64;
    localparam int CNT_W    = 32;
    localparam int SAMP_W   = 32;
    localparam int SCNT_W   = 16;
    localparam int PERIOD_W = 20;
    localparam int PROD_W   = SAMP_W + PERIOD_W;

    typedef enum logic [1:0] {
        CMD_HEADER  = 2'd0,
        CMD_ADVANCE = 2'd1,
        CMD_CLEAR   = 2'd2
    } t_cmd;

    typedef struct packed {
        t_cmd                command;
        logic [SEQ_W-1:0]    sequence_number;
        logic                timestamp_valid;
        logic [TS_W-1:0]     avtp_timestamp;
        logic [TS_W-1:0]     grandmaster_id;
        logic [TS_W-1:0]     arrival_time;
        logic [SCNT_W-1:0]   sample_delta;
    } t_in_word;

    typedef struct packed {
        logic [TS_W-1:0]     presentation_time;
        logic                have_timestamp;
        logic                master_changed;
        logic [CNT_W-1:0]    packets_seen;
        logic [CNT_W-1:0]    gaps_seen;
        logic [CNT_W-1:0]    stamp_updates;
        logic [TS_W-1:0]     last_arrival;
    } t_out_word;

    // tracker state as seen just after one word's update
    typedef struct packed {
        logic [TS_W-1:0]     stamp;
        logic [SAMP_W-1:0]   samples;
        logic                have_ts;
        logic                mchg;
        logic [CNT_W-1:0]    pkts;
        logic [CNT_W-1:0]    gaps;
        logic [CNT_W-1:0]    upds;
        logic [TS_W-1:0]     arrival;
    } t_snap;

endpackage

FILE: src/avtp_audio_stream_rx_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AVTP audio stream receive tracker
// Per-stream sequence, timestamp and grandmaster bookkeeping for AAF receive.
// ----------------------------------------------------------------------------
// Usage
//   Input channel  : i_in_valid / o_in_stall / i_in_word. A word is taken on
//                    a rising edge with valid high and stall low. Commands are
//                    packet header, advance samples and clear.
//   Output channel : o_out_valid / i_out_stall / o_out_word. Exactly one
//                    result word per input word, in order.
//   Config         : i_cfg_we / i_cfg_data writes the sample period (ns);
//                    only while the block is idle.
// Path     : an accepted word passes r_s1, r_s2 and then the output register
//   r_out, which drives o_out_valid and o_out_word.
// Throughput: one word per cycle while no stall holds the pipe. Tracker state updates at acceptance, so
//   back-to-back headers see each other's effect; the result then passes a
//   multiply stage (samples x period) and an add stage (stamp + product).
// Stall    : each stage holds while the one after it is full and stuck, so
//   up to three words sit in the pipe under a held output stall before
//   o_in_stall rises.
// Reset    : synchronous, active low. Clears tracker state, the sample period
//   and all stage valids; the pipe is empty afterwards.
// ----------------------------------------------------------------------------
module avtp_audio_stream_rx_tracker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  avtp_rx_pkg::t_in_word              i_in_word,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output avtp_rx_pkg::t_out_word             o_out_word,
    input  logic                               i_cfg_we,
    input  logic [avtp_rx_pkg::PERIOD_W-1:0]   i_cfg_data
);
    import avtp_rx_pkg::*;

    // tracker state
    logic [SEQ_W-1:0]    r_prev_seq,  n_prev_seq;
    logic [TS_W-1:0]     r_prev_gm,   n_prev_gm;
    t_snap               r_st,        n_st;
    logic [PERIOD_W-1:0] r_period;

    // pipeline
    logic                r_s1_v, r_s2_v, r_out_v;
    t_snap               r_s1, r_s2;
    logic [PROD_W-1:0]   r_s2_prod;
    t_out_word           r_out;

    logic en_out, en_s2, en_s1, in_acc, not_first;
    logic [PROD_W-1:0] n_prod;
    logic [TS_W-1:0]   n_ptime;

    // stage advance: a stage moves if empty or the next one is moving
    assign en_out = !r_out_v || !i_out_stall;
    assign en_s2  = !r_s2_v  || en_out;
    assign en_s1  = !r_s1_v  || en_s2;
    assign in_acc = i_in_valid && en_s1;

    assign o_in_stall  = !en_s1;
    assign o_out_valid = r_out_v;
    assign o_out_word  = r_out;

    assign not_first = (r_st.pkts != '0);

    // state update for the incoming word
    always_comb begin
        n_prev_seq = r_prev_seq;
        n_prev_gm  = r_prev_gm;
        n_st       = r_st;
        if (in_acc) begin
            unique case (i_in_word.command)
                CMD_HEADER: begin
                    if (not_first && (i_in_word.sequence_number != r_prev_seq + 1'b1)) begin
                        n_st.gaps = r_st.gaps + 1'b1;
                    end
                    n_prev_seq   = i_in_word.sequence_number;
                    n_st.arrival = i_in_word.arrival_time;
                    if (i_in_word.timestamp_valid) begin
                        n_st.stamp   = i_in_word.avtp_timestamp;
                        n_st.samples = '0;
                        n_st.have_ts = 1'b1;
                        n_st.upds    = r_st.upds + 1'b1;
                        if (not_first && (i_in_word.grandmaster_id != r_prev_gm)) begin
                            n_st.mchg = 1'b1;
                        end
                        n_prev_gm = i_in_word.grandmaster_id;
                    end
                    n_st.pkts = r_st.pkts + 1'b1;
                end
                CMD_ADVANCE: begin
                    n_st.samples = r_st.samples
                                 + {{(SAMP_W-SCNT_W){1'b0}}, i_in_word.sample_delta};
                end
                CMD_CLEAR: begin
                    n_prev_seq = '0;
                    n_prev_gm  = '0;
                    n_st       = '0;
                end
                default: begin
                    // unused code: state left unchanged
                end
            endcase
        end
    end

    assign n_prod  = {{PERIOD_W{1'b0}}, r_s1.samples} * {{SAMP_W{1'b0}}, r_period};
    assign n_ptime = r_s2.have_ts
                   ? r_s2.stamp + {{(TS_W-PROD_W){1'b0}}, r_s2_prod}
                   : '0;

    // control and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_seq <= '0;
            r_prev_gm  <= '0;
            r_st       <= '0;
            r_period   <= '0;
            r_s1_v     <= 1'b0;
            r_s2_v     <= 1'b0;
            r_out_v    <= 1'b0;
        end else begin
            r_prev_seq <= n_prev_seq;
            r_prev_gm  <= n_prev_gm;
            r_st       <= n_st;
            if (i_cfg_we) begin
                r_period <= i_cfg_data;
            end
            if (en_s1) begin
                r_s1_v <= i_in_valid;
            end
            if (en_s2) begin
                r_s2_v <= r_s1_v;
            end
            if (en_out) begin
                r_out_v <= r_s2_v;
            end
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1 <= n_st;
        end
        if (en_s2 && r_s1_v) begin
            r_s2      <= r_s1;
            r_s2_prod <= n_prod;
        end
        if (en_out && r_s2_v) begin
            r_out.presentation_time <= n_ptime;
            r_out.have_timestamp    <= r_s2.have_ts;
            r_out.master_changed    <= r_s2.mchg;
            r_out.packets_seen      <= r_s2.pkts;
            r_out.gaps_seen         <= r_s2.gaps;
            r_out.stamp_updates     <= r_s2.upds;
            r_out.last_arrival      <= r_s2.arrival;
        end
    end

endmodule

FILE: src/avtp_rx_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AVTP audio stream receive tracker - port checker
// Checks channel behaviour and result word consistency.
// ----------------------------------------------------------------------------
module avtp_rx_checker (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   o_in_stall,
    input  logic                   o_out_valid,
    input  logic                   i_out_stall,
    input  avtp_rx_pkg::t_out_word o_out_word
);
    import avtp_rx_pkg::*;

    // stalled result must hold
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("result word changed under stall");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid straight after reset");

    // input only backs up behind a held result
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled with the output free");

    // no stamp: zero time and no updates since clear
    a_no_stamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.have_timestamp |->
            o_out_word.presentation_time == '0 && o_out_word.stamp_updates == '0)
        else $error("time or update count without a stamp");

    // grandmaster change is only seen on a stamped header
    a_mchg_stamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.master_changed |-> o_out_word.have_timestamp)
        else $error("master change flagged without a stamp");

endmodule

bind avtp_audio_stream_rx_tracker avtp_rx_checker u_avtp_rx_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);

FILE: tb/avtp_rx_tracker_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AVTP audio stream receive tracker - scoreboard
// Follows the input, output and register ports of the tracker. It keeps its
// own copy of the stream state, predicts the status word that each accepted
// input word produces and compares each output word with the oldest one.
// ----------------------------------------------------------------------------
module avtp_rx_tracker_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               i_in_stall,
    input  avtp_rx_pkg::t_in_word              i_in_word,
    input  logic                               i_out_valid,
    input  logic                               i_out_stall,
    input  avtp_rx_pkg::t_out_word             i_out_word,
    input  logic                               i_cfg_we,
    input  logic [avtp_rx_pkg::PERIOD_W-1:0]   i_cfg_data,
    output int                                 o_pending,
    output int                                 o_fail_count
);

    import avtp_rx_pkg::*;

    // predicted stream state
    logic [PERIOD_W-1:0] period;
    logic [SEQ_W-1:0]    last_seq;
    logic [TS_W-1:0]     stamp;
    logic [TS_W-1:0]     arrival;
    logic [SAMP_W-1:0]   samples_acc;
    logic                stamp_ok;
    logic [TS_W-1:0]     last_master;
    logic                master_moved;
    logic [CNT_W-1:0]    pkt_cnt;
    logic [CNT_W-1:0]    upd_cnt;
    logic [CNT_W-1:0]    gap_cnt;

    t_out_word predicted_status[$];
    int        fail_count = 0;

    assign o_fail_count = fail_count;

    function automatic void clear_stream();
        last_seq     = '0;
        stamp        = '0;
        arrival      = '0;
        samples_acc  = '0;
        stamp_ok     = 1'b0;
        last_master  = '0;
        master_moved = 1'b0;
        pkt_cnt      = '0;
        upd_cnt      = '0;
        gap_cnt      = '0;
    endfunction

    // applies one word to the stream state, returns the status after it
    function automatic t_out_word update_tracker(t_in_word w);
        t_out_word s;
        logic      first;
        first = (pkt_cnt == '0);
        case (w.command)
            CMD_HEADER: begin
                if (!first && w.sequence_number != last_seq + 32'd1)
                    gap_cnt = gap_cnt + 32'd1;
                last_seq = w.sequence_number;
                arrival  = w.arrival_time;
                if (w.timestamp_valid) begin
                    stamp       = w.avtp_timestamp;
                    samples_acc = '0;
                    stamp_ok    = 1'b1;
                    upd_cnt     = upd_cnt + 32'd1;
                    if (!first && w.grandmaster_id != last_master)
                        master_moved = 1'b1;
                    last_master = w.grandmaster_id;
                end
                pkt_cnt = pkt_cnt + 32'd1;
            end
            CMD_ADVANCE: samples_acc = samples_acc + {16'd0, w.sample_delta};
            CMD_CLEAR:   clear_stream();
            default: ;
        endcase
        s.presentation_time = stamp_ok ?
            stamp + {32'd0, samples_acc} * {44'd0, period} : '0;
        s.have_timestamp = stamp_ok;
        s.master_changed = master_moved;
        s.packets_seen   = pkt_cnt;
        s.gaps_seen      = gap_cnt;
        s.stamp_updates  = upd_cnt;
        s.last_arrival   = arrival;
        return s;
    endfunction

    task automatic report(string msg);
        fail_count++;
        $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
        if (got !== want)
            report($sformatf("%s got %h, want %h", name, got, want));
    endtask

    always @(posedge i_clk) begin : monitor
        t_out_word want;
        if (!i_rst_n) begin
            clear_stream();
            period = '0;
            predicted_status.delete();
        end else begin
            // output before input: no word comes out in its own accept cycle
            if (i_out_valid && !i_out_stall) begin
                if (predicted_status.size() == 0) begin
                    report($sformatf("status word %h with none outstanding", i_out_word));
                end else begin
                    want = predicted_status.pop_front();
                    check_field("presentation_time", i_out_word.presentation_time,
                                want.presentation_time);
                    check_field("have_timestamp", i_out_word.have_timestamp,
                                want.have_timestamp);
                    check_field("master_changed", i_out_word.master_changed,
                                want.master_changed);
                    check_field("packets_seen", i_out_word.packets_seen,
                                want.packets_seen);
                    check_field("gaps_seen", i_out_word.gaps_seen, want.gaps_seen);
                    check_field("stamp_updates", i_out_word.stamp_updates,
                                want.stamp_updates);
                    check_field("last_arrival", i_out_word.last_arrival,
                                want.last_arrival);
                end
            end
            if (i_in_valid && !i_in_stall)
                predicted_status.push_back(update_tracker(i_in_word));
            if (i_cfg_we)
                period = i_cfg_data;
        end
        o_pending <= predicted_status.size();
    end

endmodule

FILE: tb/avtp_audio_stream_rx_tracker_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AVTP audio stream receive tracker - testbench top
// Drives header, advance, clear and spare command words into the tracker,
// throttles both channels and reprograms the sample period between phases.
// The scoreboard beside the block does all predicting and comparing.
// ----------------------------------------------------------------------------
module avtp_audio_stream_rx_tracker_test;

    import avtp_rx_pkg::*;

    // the one command code the package leaves unnamed; must change nothing
    localparam logic [1:0] CMD_SPARE = 2'd3;

    localparam int WORDS_PER_PHASE = 150;
    localparam int PHASES          = 6;
    localparam int HOLD_CYCLES     = 60;      // long output stall, fills the pipe
    localparam int DRAIN_CYCLES    = 8;       // settling margin after the last status word
    localparam int CYCLE_LIMIT     = 200000;  // watchdog bound for the whole run

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    t_in_word            in_word  = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    t_out_word           out_word;
    logic                cfg_we   = 1'b0;
    logic [PERIOD_W-1:0] cfg_data = '0;

    int          pending;
    int          fail_count;
    int unsigned cycle_count = 0;

    // idle chances in percent, changed per phase
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    logic hold_req  = 1'b0;
    logic hold_done = 1'b0;

    // running stream context for well-formed header sequences
    logic [SEQ_W-1:0] stream_seq;
    logic [TS_W-1:0]  stream_master;
    logic [TS_W-1:0]  stream_arrival;

    always #5 clk = ~clk;

    avtp_audio_stream_rx_tracker i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    avtp_rx_tracker_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_word   (out_word),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // watchdog: a hung handshake ends the run here
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // every field random, any command including the spare code
    function automatic t_in_word noise_word();
        t_in_word w;
        w.command         = t_cmd'(2'($urandom_range(0, 3)));
        w.sequence_number = $urandom;
        w.timestamp_valid = 1'($urandom);
        w.avtp_timestamp  = rand64();
        w.grandmaster_id  = rand64();
        w.arrival_time    = rand64();
        w.sample_delta    = 16'($urandom);
        return w;
    endfunction

    // unused fields stay random so that ignoring them is exercised too
    function automatic t_in_word header_word(logic [31:0] seq, logic tv,
                                             logic [63:0] ts, logic [63:0] gm,
                                             logic [63:0] arr);
        t_in_word w;
        w = noise_word();
        w.command         = CMD_HEADER;
        w.sequence_number = seq;
        w.timestamp_valid = tv;
        w.avtp_timestamp  = ts;
        w.grandmaster_id  = gm;
        w.arrival_time    = arr;
        return w;
    endfunction

    function automatic t_in_word advance_word(logic [15:0] n);
        t_in_word w;
        w = noise_word();
        w.command      = CMD_ADVANCE;
        w.sample_delta = n;
        return w;
    endfunction

    function automatic t_in_word command_word(logic [1:0] code);
        t_in_word w;
        w = noise_word();
        w.command = t_cmd'(code);
        return w;
    endfunction

    // Mostly an in-order stream: consecutive sequence numbers, a stable
    // grandmaster and rising arrival times, with the odd jump, master swap,
    // clear, spare code and pure noise word mixed in.
    function automatic t_in_word next_stream_word();
        t_in_word w;
        int       pick;
        w    = noise_word();
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            w.command = CMD_HEADER;
            if ($urandom_range(0, 19) == 0)
                w.sequence_number = $urandom;      // lost or reordered packet
            else
                w.sequence_number = stream_seq;
            stream_seq        = w.sequence_number + 32'd1;
            w.timestamp_valid = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 24) == 0)
                stream_master = rand64();
            w.grandmaster_id  = stream_master;
            stream_arrival    = stream_arrival + 64'($urandom_range(1, 200000));
            w.arrival_time    = stream_arrival;
        end else if (pick < 88) begin
            w.command      = CMD_ADVANCE;
            w.sample_delta = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                          : 16'($urandom_range(0, 192));
        end else if (pick < 91) begin
            w.command = CMD_CLEAR;
        end else if (pick < 93) begin
            w.command = t_cmd'(CMD_SPARE);
        end
        return w;
    endfunction

    // Offers one word, with random idle cycles first. Valid stays high from
    // one word to the next when no gap is drawn.
    task automatic send_word(t_in_word w);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // drops valid, waits for every status word, then lets the pipe settle
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // period register is only touched with the tracker idle
    task automatic write_period(logic [PERIOD_W-1:0] value);
        wait_drained();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // Receiving side: random stalls, plus one long hold-off on request while
    // the sender keeps offering, so the tracker has to stall its input.
    initial begin : receiver
        forever begin
            @(posedge clk);
            if (hold_req && !hold_done) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end else begin
                out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
            end
        end
    end

    initial begin : stimulus
        int seg;
        int n;
        logic [PERIOD_W-1:0] period;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 28;
        recv_idle_pct = 70;

        // --- directed: edge values and the corner cases of the tracker ---
        write_period(20'hFFFFF);
        // advance before any stamp: time stays zero
        send_word(advance_word(16'hFFFF));
        // first packet with the top sequence number: never a gap
        send_word(header_word(32'hFFFF_FFFF, 1'b0, '1, '1, 64'hFFFF_FFFF_FFFF_FFFF));
        // sequence wraps to zero; master compared against a zero identity
        send_word(header_word(32'h0, 1'b1, 64'hFFFF_FFFF_FFFF_FFF0, 64'h0, 64'h0));
        // presentation time wraps past 2^64
        send_word(advance_word(16'hFFFF));
        send_word(advance_word(16'h0000));
        // jump in sequence, new master
        send_word(header_word(32'd5, 1'b1, 64'h0, '1, 64'h1234));
        // identity ignored without a stamp
        send_word(header_word(32'd6, 1'b0, 64'h0, 64'h5555, 64'h5678));
        // header with every bit set, then the spare code and a clear
        send_word(header_word('1, 1'b1, '1, '1, '1));
        send_word(command_word(CMD_SPARE));
        send_word(command_word(CMD_CLEAR));
        // first packet after clear: no gap, no master change
        send_word(header_word(32'd100, 1'b1, 64'd1000, 64'h1234, 64'd10));
        send_word(header_word(32'd101, 1'b1, 64'd2000, 64'h1234, 64'd20));
        // repeated sequence number and a master swap
        send_word(header_word(32'd101, 1'b1, 64'd3000, 64'hAAAA_5555_AAAA_5555, 64'd30));
        send_word(advance_word(16'd1));
        send_word(command_word(CMD_CLEAR));
        // stampless first packet leaves the stored identity at zero
        send_word(header_word(32'h8000_0000, 1'b0, '1, 64'h0, 64'd40));
        send_word(header_word(32'h8000_0001, 1'b1, 64'h5555_AAAA_5555_AAAA,
                              64'h0000_0000_0000_0001, 64'd50));
        send_word(advance_word(16'hFFFF));
        send_word(advance_word(16'h8000));

        // --- random phases: idling pattern changes every two phases ---
        for (seg = 0; seg < PHASES; seg++) begin
            case (seg / 2)
                0: begin send_idle_pct = 28; recv_idle_pct = 70; end
                1: begin send_idle_pct = 70; recv_idle_pct = 28; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            case (seg)
                0: period = 20'd0;
                1: period = 20'd20833;                // 48 kHz
                2: period = 20'd1;
                3: period = 20'd1000000;
                4: period = 20'($urandom_range(0, 1000000));
                default: period = 20'd22676;          // 44.1 kHz
            endcase
            write_period(period);
            stream_seq     = $urandom;
            stream_master  = rand64();
            stream_arrival = rand64();
            if (seg == 4)
                hold_req = 1'b1;
            for (n = 0; n < WORDS_PER_PHASE; n++)
                send_word(next_stream_word());
        end

        wait_drained();
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: avtp_audio_stream_rx_tracker.f
src/avtp_rx_pkg.sv
src/avtp_audio_stream_rx_tracker.sv
src/avtp_rx_checker.sv
tb/avtp_rx_tracker_checker.sv
tb/avtp_audio_stream_rx_tracker_test.sv
